[design/assert_macros.svh]
// Assertion macros shared by the gap-junction plasticity block.
// Holds only macro definitions; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, ignored while reset is held.
`define LGJP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define LGJP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/lgjp_pkg.sv]
// Package of the gap-junction plasticity block: sizes, codes and the
// command and status structs between controller and datapath. No dependencies.
package lgjp_pkg;

  localparam int NEURONS   = 64;
  localparam int TRI_DEPTH = NEURONS * (NEURONS - 1) / 2;
  localparam int ADDR_W    = $clog2(TRI_DEPTH);
  localparam int IDX_W     = 6;
  localparam int W_W       = 24;

  // Item kinds
  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // Register indexes
  localparam logic [2:0] CFG_DEP_RATE  = 3'd0;
  localparam logic [2:0] CFG_POT_RATE  = 3'd1;
  localparam logic [2:0] CFG_WARMUP    = 3'd2;
  localparam logic [2:0] CFG_CONNECT   = 3'd3;
  localparam logic [2:0] CFG_SPLIT     = 3'd4;
  localparam logic [2:0] CFG_SPAN      = 3'd5;

  // Controller to datapath
  typedef struct packed {
    logic clr;      // zero the entry under the clear counter
    logic load;     // capture an accepted item
    logic prep;     // form row base, pair address and change
    logic walk_rd;  // read the next weight of the row
    logic wr_pair;  // store write data at the pair address
    logic rd_pair;  // read the pair address
    logic respond;  // register the result for its strobe
  } lgjp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic upd_go;
    logic wr_go;
    logic rd_go;
    logic walk_last;
  } lgjp_sts_t;

endpackage

[design/local_gap_junction_plasticity.sv]
// Top level of the local gap-junction plasticity block: ties controller and
// datapath together. Depends on lgjp_pkg, lgjp_ctrl and lgjp_dpath.
//
//   channel  ports                      handshake
//   input    in_*                       taken when start is high and busy low
//   result   out_read_weight, status    out_valid high for one cycle, no stall
//   config   cfg_we, cfg_index, cfg_data written at any edge with cfg_we high
//
// Each item passes capture and prepare; then an update reads each stored
// weight of its row on the single memory read port and ends with the last
// write-back, a write stores, and a read reads and registers the data. After
// reset a clearing pass zeroes the 2016 weights, one per cycle, with busy
// high. The result is registered; the next item may be taken while it shows.
module local_gap_junction_plasticity
  import lgjp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_kind,
  input  logic [IDX_W-1:0] in_neuron,
  input  logic [IDX_W-1:0] in_partner,
  input  logic [15:0]      in_burst_level,
  input  logic             in_potentiate,
  input  logic [31:0]      in_step,
  input  logic [W_W-1:0]   in_weight_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  output logic             out_valid,
  output logic [W_W-1:0]   out_read_weight,
  output logic             out_status
);

  lgjp_cmd_t cmd;
  lgjp_sts_t sts;

  lgjp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  lgjp_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_kind),
    .in_neuron       (in_neuron),
    .in_partner      (in_partner),
    .in_burst_level  (in_burst_level),
    .in_potentiate   (in_potentiate),
    .in_step         (in_step),
    .in_weight_data  (in_weight_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_read_weight (out_read_weight),
    .out_status      (out_status)
  );

endmodule

[design/lgjp_ctrl.sv]
// Controller of the gap-junction plasticity block: sequences clearing,
// row walks and single accesses. Depends on lgjp_pkg.
module lgjp_ctrl
  import lgjp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  lgjp_sts_t sts,
  output lgjp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PREP, S_WALK, S_FLUSH, S_WRITE, S_READ, S_RDATA
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  // Pick the next state from the datapath status
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_PREP;
      S_PREP: begin
        if (sts.upd_go)     state_nxt = S_WALK;
        else if (sts.wr_go) state_nxt = S_WRITE;
        else if (sts.rd_go) state_nxt = S_READ;
        else                state_nxt = S_IDLE;
      end
      S_WALK:  if (sts.walk_last) state_nxt = S_FLUSH;
      S_FLUSH: state_nxt = S_IDLE;
      S_WRITE: state_nxt = S_IDLE;
      S_READ:  state_nxt = S_RDATA;
      S_RDATA: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Decode commands from the state
  always_comb begin
    cmd         = '0;
    cmd.clr     = (state_r == S_CLEAR);
    cmd.load    = (state_r == S_IDLE) && start;
    cmd.prep    = (state_r == S_PREP);
    cmd.walk_rd = (state_r == S_WALK);
    cmd.wr_pair = (state_r == S_WRITE);
    cmd.rd_pair = (state_r == S_READ);
    cmd.respond = ((state_r == S_PREP) && !sts.upd_go && !sts.wr_go && !sts.rd_go)
                  || (state_r == S_FLUSH) || (state_r == S_WRITE)
                  || (state_r == S_RDATA);
  end

  // Hold state and the busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

[design/lgjp_dpath.sv]
// Datapath of the gap-junction plasticity block: registers, weight memory,
// update arithmetic and connection mask. Depends on lgjp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lgjp_dpath
  import lgjp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  lgjp_cmd_t        cmd,
  output lgjp_sts_t        sts,
  input  logic [1:0]       in_kind,
  input  logic [IDX_W-1:0] in_neuron,
  input  logic [IDX_W-1:0] in_partner,
  input  logic [15:0]      in_burst_level,
  input  logic             in_potentiate,
  input  logic [31:0]      in_step,
  input  logic [W_W-1:0]   in_weight_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  output logic             out_valid,
  output logic [W_W-1:0]   out_read_weight,
  output logic             out_status
);

  // Configuration registers
  logic [23:0] dep_rate_r, pot_rate_r;
  logic [31:0] warmup_r, connect_r;
  logic [6:0]  split_r, span_r;

  // Captured item
  logic [1:0]       kind_r;
  logic [IDX_W-1:0] i_r, j_r;
  logic             pot_r;
  logic [31:0]      step_r;
  logic [W_W-1:0]   wdata_r;
  logic [39:0]      prod_r;

  // Prepared values
  logic signed [41:0] change_r;
  logic [ADDR_W-1:0]  base_r, pair_addr_r;
  logic [IDX_W-1:0]   col_r;

  // Memory and write-back stage
  logic [W_W-1:0]    mem [TRI_DEPTH];
  logic [W_W-1:0]    rdata_r;
  logic              wb_vld_r;
  logic [ADDR_W-1:0] wb_addr_r;
  logic [IDX_W-1:0]  wb_col_r;
  logic [ADDR_W-1:0] clr_addr_r;

  logic             out_valid_r;
  logic [W_W-1:0]   out_read_weight_r;
  logic             out_status_r;

  logic i_ok, j_ok, acc, eq, final_mask;
  logic [IDX_W-1:0]  row_hi, row_lo;
  logic [31:0]       pos;
  logic signed [40:0] diff;
  logic [ADDR_W-1:0] walk_addr, rd_addr, wr_addr;
  logic [W_W-1:0]    wr_data, new_w;
  logic              we;
  logic signed [42:0] x;
  logic [29:0]       q;

  function automatic logic in_range(logic [IDX_W-1:0] v);
    return (32'(v) < NEURONS);
  endfunction

  function automatic logic [ADDR_W-1:0] tri_base(logic [IDX_W-1:0] r);
    logic [2*IDX_W-1:0] p;
    p = (2*IDX_W)'(r) * (2*IDX_W)'(r - 1'b1);
    return ADDR_W'(p >> 1);
  endfunction

  function automatic logic mask_ok(logic [IDX_W-1:0] m, logic [IDX_W-1:0] n,
                                   logic fin, logic [6:0] c, logic [6:0] s);
    logic signed [8:0] lo, hi, ms, ns;
    logic a;
    lo = $signed({2'b00, c}) - $signed({2'b00, s});
    hi = $signed({2'b00, c}) + $signed({2'b00, s});
    ms = $signed({3'b000, m});
    ns = $signed({3'b000, n});
    if (fin) a = ((ms < hi) && (ns < hi)) || ((ms >= lo) && (ns >= lo));
    else     a = ((ms < lo) && (ns < lo)) || ((ms >= hi) && (ns >= hi));
    return a && (m != n);
  endfunction

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dep_rate_r <= 24'd32883;
      pot_rate_r <= 24'd16442;
      warmup_r   <= 32'd1000;
      connect_r  <= 32'd100000;
      split_r    <= 7'd32;
      span_r     <= 7'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEP_RATE: dep_rate_r <= cfg_data[23:0];
        CFG_POT_RATE: pot_rate_r <= cfg_data[23:0];
        CFG_WARMUP:   warmup_r   <= cfg_data;
        CFG_CONNECT:  connect_r  <= cfg_data;
        CFG_SPLIT:    split_r    <= cfg_data[6:0];
        CFG_SPAN:     span_r     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Capture the item and the depression product
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      i_r     <= in_neuron;
      j_r     <= in_partner;
      pot_r   <= in_potentiate;
      step_r  <= in_step;
      wdata_r <= in_weight_data;
      prod_r  <= 40'(dep_rate_r) * 40'(in_burst_level);
    end
  end

  // Decode the captured item
  always_comb begin
    i_ok          = in_range(i_r);
    j_ok          = in_range(j_r);
    acc           = ((kind_r == KIND_WRITE) || (kind_r == KIND_READ)) && i_ok && j_ok;
    eq            = acc && (i_r == j_r);
    final_mask    = step_r > connect_r;
    sts.upd_go    = (kind_r == KIND_UPDATE) && i_ok && (step_r > warmup_r) && (i_r != '0);
    sts.wr_go     = acc && !eq && (kind_r == KIND_WRITE);
    sts.rd_go     = acc && !eq && (kind_r == KIND_READ);
    sts.walk_last = (col_r == i_r - 1'b1);
    sts.clr_last  = (clr_addr_r == ADDR_W'(TRI_DEPTH - 1));
    row_hi        = (i_r > j_r) ? i_r : j_r;
    row_lo        = (i_r > j_r) ? j_r : i_r;
    pos           = pot_r ? {pot_rate_r, 8'h00} : 32'd0;
    diff          = $signed({9'd0, pos}) - $signed({1'b0, prod_r});
  end

  // Form change, row base and pair address; advance the column
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      change_r    <= {diff, 1'b0};
      base_r      <= tri_base(i_r);
      pair_addr_r <= tri_base(row_hi) + ADDR_W'(row_lo);
      col_r       <= '0;
    end else if (cmd.walk_rd) begin
      col_r <= col_r + 1'b1;
    end
  end

  // Advance the clear counter
  always_ff @(posedge clk) begin
    if (!rst_n)       clr_addr_r <= '0;
    else if (cmd.clr) clr_addr_r <= clr_addr_r + 1'b1;
  end

  assign walk_addr = base_r + ADDR_W'(col_r);
  assign rd_addr   = cmd.rd_pair ? pair_addr_r : walk_addr;

  // Read the memory, registered
  always_ff @(posedge clk) begin
    if (cmd.walk_rd || cmd.rd_pair) rdata_r <= mem[rd_addr];
  end

  // Track the write-back stage of the row walk
  always_ff @(posedge clk) begin
    if (!rst_n) wb_vld_r <= 1'b0;
    else        wb_vld_r <= cmd.walk_rd;
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_rd) begin
      wb_addr_r <= walk_addr;
      wb_col_r  <= col_r;
    end
  end

  // Apply the change: clamp at zero, saturate, mask
  always_comb begin
    x = $signed({7'd0, rdata_r, 12'd0}) + $signed({change_r[41], change_r});
    q = x[42] ? 30'd0 : x[41:12];
    if (!mask_ok(i_r, wb_col_r, final_mask, split_r, span_r)) new_w = '0;
    else if (|q[29:24])                                      new_w = '1;
    else                                                     new_w = q[23:0];
  end

  // Select the memory write
  always_comb begin
    we = cmd.clr || wb_vld_r || cmd.wr_pair;
    if (cmd.clr) begin
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else if (wb_vld_r) begin
      wr_addr = wb_addr_r;
      wr_data = new_w;
    end else begin
      wr_addr = pair_addr_r;
      wr_data = wdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
  end

  // Register the result and its strobe
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= cmd.respond;
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      out_read_weight_r <= sts.rd_go ? rdata_r : '0;
      out_status_r      <= eq;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_weight = out_read_weight_r;
  assign out_status      = out_status_r;

  `LGJP_ASSERT(a_no_wb_in_clear, clk, rst_n, !(cmd.clr && wb_vld_r), "write-back during clear")
  `LGJP_ASSERT(a_wb_in_range, clk, rst_n, wb_vld_r |-> (wb_addr_r < TRI_DEPTH), "wb addr range")
  `LGJP_ASSERT(a_single_strobe, clk, rst_n, out_valid_r |=> !out_valid_r, "strobe too long")
  `LGJP_ASSERT(a_load_idle, clk, rst_n, !(cmd.load && (cmd.walk_rd || wb_vld_r)), "load in walk")

endmodule

[test/tb.sv]
// Testbench of the local gap-junction plasticity block: directed and random items
// are checked against an in-bench model of the lower-triangle weight matrix.
// Depends on lgjp_pkg and local_gap_junction_plasticity.
module tb;
  import lgjp_pkg::*;

  localparam logic [1:0]     KIND_SPARE  = 2'd3;
  localparam logic [W_W-1:0] W_TOP       = 24'hFFFFFF;
  localparam int             STALL_LIMIT = 20000;
  localparam int             SETTLE_CYC  = 3;
  localparam int             TAIL_CYC    = 80;
  localparam int             MAX_SHOWN   = 10;

  typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN} op_t;

  // One pending step of the stimulus: an item, a register write or a pause
  typedef struct {
    op_t              op;
    logic [1:0]       kind;
    logic [IDX_W-1:0] neuron;
    logic [IDX_W-1:0] partner;
    logic [15:0]      burst;
    logic             pot;
    logic [31:0]      step;
    logic [W_W-1:0]   wdata;
    logic [2:0]       reg_idx;
    logic [31:0]      reg_val;
    int               gap;
  } plan_t;

  typedef struct {
    logic [1:0]       kind;
    logic [IDX_W-1:0] neuron;
    logic [IDX_W-1:0] partner;
    logic [W_W-1:0]   read_weight;
    logic             status;
  } res_t;

  logic             clk;
  logic             rst_n          = 1'b0;
  logic             start          = 1'b0;
  logic             busy;
  logic [1:0]       in_kind        = '0;
  logic [IDX_W-1:0] in_neuron      = '0;
  logic [IDX_W-1:0] in_partner     = '0;
  logic [15:0]      in_burst_level = '0;
  logic             in_potentiate  = 1'b0;
  logic [31:0]      in_step        = '0;
  logic [W_W-1:0]   in_weight_data = '0;
  logic             cfg_we         = 1'b0;
  logic [2:0]       cfg_index      = '0;
  logic [31:0]      cfg_data       = '0;
  logic             out_valid;
  logic [W_W-1:0]   out_read_weight;
  logic             out_status;

  // Model of the weight matrix and its settings
  logic [W_W-1:0] wt_mem [TRI_DEPTH];
  logic [23:0]    dep_rate = 24'd32883;
  logic [23:0]    pot_rate = 24'd16442;
  logic [31:0]    warm_r   = 32'd1000;
  logic [31:0]    conn_r   = 32'd100000;
  logic [6:0]     split_r  = 7'd32;
  logic [6:0]     span_r   = 7'd0;

  plan_t plan_q [$];
  res_t  res_q [$];
  plan_t cur;
  int    gap_cnt      = 0;
  int    quiet_cnt    = 0;
  int    n_accepted   = 0;
  int    n_results    = 0;
  int    err_cnt      = 0;
  int    stall_cnt    = 0;
  int    stretch_left = 0;
  bit    calm         = 1'b0;
  logic [31:0] gen_warm = 32'd1000;
  logic [31:0] gen_conn = 32'd100000;

  local_gap_junction_plasticity uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_neuron       (in_neuron),
    .in_partner      (in_partner),
    .in_burst_level  (in_burst_level),
    .in_potentiate   (in_potentiate),
    .in_step         (in_step),
    .in_weight_data  (in_weight_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_read_weight (out_read_weight),
    .out_status      (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Position of pair (r,c), r>c, in the packed lower triangle
  function automatic int slot(input int r, input int c);
    return r * (r - 1) / 2 + c;
  endfunction

  // Queue one item; idle gaps come in stretches, some of them with no gaps at all
  task automatic push_item(input logic [1:0] kind, input int nrn, input int prt,
                           input logic [15:0] burst, input logic pot,
                           input logic [31:0] step, input logic [W_W-1:0] wdata);
    plan_t p;
    if (stretch_left == 0) begin
      stretch_left = $urandom_range(10, 60);
      calm = ($urandom_range(0, 2) == 0);
    end
    stretch_left--;
    p.op      = OP_ITEM;
    p.kind    = kind;
    p.neuron  = nrn[IDX_W-1:0];
    p.partner = prt[IDX_W-1:0];
    p.burst   = burst;
    p.pot     = pot;
    p.step    = step;
    p.wdata   = wdata;
    p.reg_idx = '0;
    p.reg_val = '0;
    p.gap     = calm ? 0 : $urandom_range(0, 16);
    plan_q    = {plan_q, p};
  endtask

  // Queue a write of all six registers; garble sets bits above each narrow register's width
  task automatic set_phase(input logic [23:0] dep, input logic [23:0] pot,
                           input logic [31:0] warm, input logic [31:0] conn,
                           input logic [6:0] split, input logic [6:0] span,
                           input bit garble);
    logic [2:0]  regs [6];
    logic [31:0] vals [6];
    plan_t       p;
    regs = '{CFG_DEP_RATE, CFG_POT_RATE, CFG_WARMUP, CFG_CONNECT, CFG_SPLIT, CFG_SPAN};
    vals = '{{8'd0, dep}, {8'd0, pot}, warm, conn, {25'd0, split}, {25'd0, span}};
    if (garble) begin
      vals[0][31:24] = 8'($urandom);
      vals[1][31:24] = 8'($urandom);
      vals[4][31:7]  = 25'($urandom);
      vals[5][31:7]  = 25'($urandom);
    end
    for (int k = 0; k < 6; k++) begin
      p.op      = OP_CFG;
      p.reg_idx = regs[k];
      p.reg_val = vals[k];
      p.gap     = 0;
      plan_q    = {plan_q, p};
    end
    gen_warm = warm;
    gen_conn = conn;
  endtask

  // Random part: mostly write / update / read-back runs on one row, the rest noise
  task automatic gen_phase(input int n_items);
    int             made, row, col, nw, nr;
    bit             swap;
    logic [1:0]     kind;
    logic [31:0]    step;
    logic [15:0]    burst;
    logic [W_W-1:0] wd;
    plan_t          p;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 99) < 72) begin
        row = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 63) : $urandom_range(1, 63);
        nw  = $urandom_range(0, 3);
        repeat (nw) begin
          col  = $urandom_range(0, row - 1);
          swap = 1'($urandom_range(0, 1));
          case ($urandom_range(0, 5))
            0:       wd = '0;
            1:       wd = W_TOP;
            2:       wd = 24'($urandom_range(0, 4095));
            default: wd = 24'($urandom);
          endcase
          push_item(KIND_WRITE, swap ? col : row, swap ? row : col,
                    16'($urandom), 1'($urandom), $urandom, wd);
        end
        // steps around the warm-up and connect thresholds
        case ($urandom_range(0, 7))
          0:       step = $urandom_range(0, gen_warm);
          1:       step = gen_conn;
          2:       step = gen_conn + 1;
          3:       step = $urandom;
          default: step = gen_warm + 1 + $urandom_range(0, 4000);
        endcase
        case ($urandom_range(0, 7))
          0:       burst = '0;
          1:       burst = 16'hFFFF;
          2:       burst = 16'($urandom);
          default: burst = 16'($urandom_range(0, 1023));
        endcase
        push_item(KIND_UPDATE, row, $urandom_range(0, 63), burst,
                  1'($urandom_range(0, 1)), step, 24'($urandom));
        nr = $urandom_range(1, 3);
        repeat (nr) begin
          col  = $urandom_range(0, row - 1);
          swap = 1'($urandom_range(0, 1));
          push_item(KIND_READ, swap ? col : row, swap ? row : col,
                    16'($urandom), 1'($urandom), $urandom, 24'($urandom));
        end
        made += nw + 1 + nr;
        // hold the sender now and then until every result is back
        if ($urandom_range(0, 24) == 0) begin
          p.op   = OP_DRAIN;
          p.gap  = 0;
          plan_q = {plan_q, p};
        end
      end else begin
        kind = 2'($urandom_range(0, 3));
        row  = $urandom_range(0, 63);
        col  = ($urandom_range(0, 3) == 0) ? row : $urandom_range(0, 63);
        push_item(kind, row, col, 16'($urandom), 1'($urandom_range(0, 1)), $urandom,
                  24'($urandom));
        made++;
      end
    end
  endtask

  // Driver: predict each taken item, then present the next step of the plan
  always @(posedge clk) begin : drive
    res_t        r;
    plan_t       p;
    logic        go, we, fin, open;
    int          row, col, c, s, pos;
    longint      delta, acc;
    if (!rst_n) begin
      start     <= 1'b0;
      cfg_we    <= 1'b0;
      quiet_cnt = 0;
      gap_cnt   = 0;
    end else begin
      go = start;
      we = 1'b0;
      if (start && !busy) begin
        r.kind        = cur.kind;
        r.neuron      = cur.neuron;
        r.partner     = cur.partner;
        r.read_weight = '0;
        r.status      = 1'b0;
        if (cur.kind == KIND_UPDATE) begin
          // adjust the whole row, clamp, saturate and apply the connection mask
          if (cur.step > warm_r) begin
            fin   = cur.step > conn_r;
            c     = int'(split_r);
            s     = int'(span_r);
            delta = 2 * ((cur.pot ? longint'(pot_rate) * 256 : 64'sd0)
                         - longint'(dep_rate) * longint'(cur.burst));
            row   = int'(cur.neuron);
            for (col = 0; col < row; col++) begin
              pos = slot(row, col);
              acc = (longint'(wt_mem[pos]) <<< 12) + delta;
              if (acc < 0) acc = 0;
              acc = acc >>> 12;
              if (acc > longint'(W_TOP)) acc = longint'(W_TOP);
              if (fin) open = (row < c + s && col < c + s) || (row >= c - s && col >= c - s);
              else     open = (row < c - s && col < c - s) || (row >= c + s && col >= c + s);
              wt_mem[pos] = open ? acc[W_W-1:0] : '0;
            end
          end
        end else if (cur.kind == KIND_WRITE || cur.kind == KIND_READ) begin
          if (cur.neuron == cur.partner) begin
            r.status = 1'b1;
          end else begin
            // the matrix is symmetric: always address the lower triangle
            pos = (cur.neuron > cur.partner) ? slot(cur.neuron, cur.partner)
                                             : slot(cur.partner, cur.neuron);
            if (cur.kind == KIND_WRITE) wt_mem[pos] = cur.wdata;
            else r.read_weight = wt_mem[pos];
          end
        end
        res_q = {res_q, r};
        n_accepted++;
        go      = 1'b0;
        gap_cnt = cur.gap;
      end

      // count how long nothing is in flight, to tell when the block is idle
      if (!start && !busy && !out_valid && n_accepted == n_results) quiet_cnt++;
      else quiet_cnt = 0;

      if (!go) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (plan_q.size() != 0) begin
          if (plan_q[0].op == OP_ITEM) begin
            cur            = plan_q.pop_front();
            go             = 1'b1;
            in_kind        <= cur.kind;
            in_neuron      <= cur.neuron;
            in_partner     <= cur.partner;
            in_burst_level <= cur.burst;
            in_potentiate  <= cur.pot;
            in_step        <= cur.step;
            in_weight_data <= cur.wdata;
          end else if (quiet_cnt >= SETTLE_CYC) begin
            p = plan_q.pop_front();
            if (p.op == OP_CFG) begin
              we        = 1'b1;
              cfg_index <= p.reg_idx;
              cfg_data  <= p.reg_val;
              case (p.reg_idx)
                CFG_DEP_RATE: dep_rate = p.reg_val[23:0];
                CFG_POT_RATE: pot_rate = p.reg_val[23:0];
                CFG_WARMUP:   warm_r   = p.reg_val;
                CFG_CONNECT:  conn_r   = p.reg_val;
                CFG_SPLIT:    split_r  = p.reg_val[6:0];
                CFG_SPAN:     span_r   = p.reg_val[6:0];
                default: ;
              endcase
            end
          end
        end
      end
      start  <= go;
      cfg_we <= we;
    end
  end

  // Monitor: compare every strobed result with the oldest prediction
  always @(posedge clk) begin : check
    res_t w;
    if (rst_n && out_valid) begin
      n_results++;
      if (res_q.size() == 0) begin
        if (err_cnt < MAX_SHOWN)
          $display("result with no item pending: read_weight %h status %b",
                   out_read_weight, out_status);
        err_cnt++;
      end else begin
        w = res_q.pop_front();
        if (out_read_weight !== w.read_weight || out_status !== w.status) begin
          if (err_cnt < MAX_SHOWN)
            $display("kind %0d (%0d,%0d): read_weight %h expected %h, status %b expected %b",
                     w.kind, w.neuron, w.partner, out_read_weight, w.read_weight,
                     out_status, w.status);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt == STALL_LIMIT) begin
      $display("no progress for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    foreach (wt_mem[k]) wt_mem[k] = '0;

    // directed items under reset settings
    push_item(KIND_WRITE, 5, 2, 16'h0000, 1'b0, 32'h0, 24'hFFFFFF);
    push_item(KIND_READ, 2, 5, 16'hFFFF, 1'b1, 32'hFFFFFFFF, 24'h000000);
    push_item(KIND_WRITE, 63, 0, 16'h0000, 1'b0, 32'h0, 24'h000001);
    // upper-triangle pair overwrites the same entry, masked pair stores as given
    push_item(KIND_WRITE, 0, 63, 16'h0000, 1'b0, 32'h0, 24'hABCDEF);
    push_item(KIND_READ, 63, 0, 16'h0000, 1'b0, 32'h0, 24'h000000);
    // equal indices
    push_item(KIND_WRITE, 7, 7, 16'h1234, 1'b0, 32'h0, 24'h555555);
    push_item(KIND_READ, 0, 0, 16'h0000, 1'b0, 32'h0, 24'h000000);
    push_item(KIND_READ, 63, 63, 16'hFFFF, 1'b1, 32'hFFFFFFFF, 24'hFFFFFF);
    // unused kind
    push_item(KIND_SPARE, 63, 1, 16'hFFFF, 1'b1, 32'hFFFFFFFF, 24'hFFFFFF);
    // step equal to the warm-up count leaves the row alone
    push_item(KIND_UPDATE, 63, 0, 16'hFFFF, 1'b0, 32'd1000, 24'h000000);
    push_item(KIND_READ, 63, 0, 16'h0000, 1'b0, 32'h0, 24'h000000);
    // potentiation saturates a full weight
    push_item(KIND_UPDATE, 5, 9, 16'h0000, 1'b1, 32'd1001, 24'h000000);
    push_item(KIND_READ, 5, 2, 16'h0000, 1'b0, 32'h0, 24'h000000);
    push_item(KIND_READ, 1, 5, 16'h0000, 1'b0, 32'h0, 24'h000000);
    // initial mask zeroes pairs across the cluster boundary
    push_item(KIND_UPDATE, 63, 0, 16'h0000, 1'b0, 32'd100000, 24'h000000);
    push_item(KIND_READ, 63, 0, 16'h0000, 1'b0, 32'h0, 24'h000000);
    // final mask keeps pairs inside the second cluster
    push_item(KIND_WRITE, 40, 33, 16'h0000, 1'b0, 32'h0, 24'h123456);
    push_item(KIND_UPDATE, 40, 0, 16'h0100, 1'b1, 32'd100001, 24'h000000);
    push_item(KIND_READ, 33, 40, 16'h0000, 1'b0, 32'h0, 24'h000000);
    // row without stored weights, then depression clamped at zero
    push_item(KIND_UPDATE, 0, 63, 16'hFFFF, 1'b1, 32'hFFFFFFFF, 24'hFFFFFF);
    push_item(KIND_UPDATE, 40, 63, 16'hFFFF, 1'b0, 32'hFFFFFFFF, 24'h000000);
    push_item(KIND_READ, 39, 40, 16'h0000, 1'b0, 32'h0, 24'h000000);
    push_item(KIND_WRITE, 1, 0, 16'h0000, 1'b0, 32'h0, 24'h800000);
    push_item(KIND_UPDATE, 1, 0, 16'h0000, 1'b0, 32'hFFFFFFFF, 24'h000000);
    push_item(KIND_READ, 0, 1, 16'h0000, 1'b0, 32'h0, 24'h000000);

    // random phases over several settings, extremes included
    set_phase(24'd0, 24'hFFFFFF, 32'd0, 32'd0, 7'd64, 7'd64, 1'b0);
    gen_phase(170);
    set_phase(24'hFFFFFF, 24'd1, 32'hFFFFFFFF, 32'hFFFFFFFF, 7'd0, 7'd0, 1'b0);
    gen_phase(40);
    set_phase(24'($urandom_range(0, 65535)), 24'($urandom_range(0, 131071)),
              $urandom_range(0, 3000), $urandom_range(0, 6000),
              7'($urandom_range(0, 64)), 7'($urandom_range(0, 20)), 1'b1);
    gen_phase(170);
    set_phase(24'($urandom_range(0, 65535)), 24'($urandom_range(0, 131071)),
              $urandom_range(0, 3000), $urandom_range(0, 6000),
              7'($urandom_range(0, 64)), 7'($urandom_range(0, 64)), 1'b1);
    gen_phase(170);
    set_phase(24'd32883, 24'd16442, 32'd1000, 32'd100000, 7'd32, 7'd0, 1'b0);
    gen_phase(130);

    // release reset after the clearing-pass-free hold
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // drain, then let the block settle before the verdict
    while (plan_q.size() != 0 || start || n_results != n_accepted) @(negedge clk);
    repeat (TAIL_CYC) @(negedge clk);
    if (res_q.size() != 0) $display("%0d results never arrived", res_q.size());
    if (err_cnt == 0 && res_q.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/lgjp_pkg.sv
design/lgjp_ctrl.sv
design/lgjp_dpath.sv
design/local_gap_junction_plasticity.sv
test/tb.sv
